@@ rtl/ftl_pkg.sv @@
// Shared constants, token codes, descriptor types and character helpers
// for the Forth token lexer. No dependencies.
package ftl_pkg;

  // Sizing
  localparam int NAME_CAPACITY   = 32;
  localparam int STRING_CAPACITY = 32;
  localparam int CELL_BITS       = 32;
  localparam int DEPTH_BITS      = 16;
  localparam int STORE_DEPTH     = (NAME_CAPACITY > STRING_CAPACITY) ?
                                   NAME_CAPACITY : STRING_CAPACITY;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);
  localparam int CNT_W           = $clog2(STORE_DEPTH + 1);

  // Token kinds
  localparam logic [3:0] K_EOF   = 4'd0;
  localparam logic [3:0] K_NUM   = 4'd1;
  localparam logic [3:0] K_IDENT = 4'd2;
  localparam logic [3:0] K_TICK  = 4'd3;
  localparam logic [3:0] K_STR   = 4'd4;
  localparam logic [3:0] K_OPEN  = 4'd5;
  localparam logic [3:0] K_POPEN = 4'd6;
  localparam logic [3:0] K_CLOSE = 4'd7;
  localparam logic [3:0] K_ERR   = 4'd8;

  // Error codes
  localparam logic [2:0] E_OPEN_COMMENT = 3'd0;
  localparam logic [2:0] E_STRAY_PAREN  = 3'd1;
  localparam logic [2:0] E_WORD_LONG    = 3'd2;
  localparam logic [2:0] E_OPEN_STRING  = 3'd3;
  localparam logic [2:0] E_STRING_LONG  = 3'd4;
  localparam logic [2:0] E_BAD_ESCAPE   = 3'd5;

  // One token as handed from front to back
  typedef struct packed {
    logic [3:0]       kind;
    logic [31:0]      value;
    logic [CNT_W-1:0] len;
    logic [2:0]       err;
  } tok_desc_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  endfunction

  function automatic logic is_dec_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == "[") || (c == "]") || (c == ";") || (c == "(") || (c == ")") ||
           (c == 8'h22) || (c == 8'h27) || (c == 8'h00) || is_space(c);
  endfunction

  function automatic logic is_text_kind(input logic [3:0] k);
    return (k == K_IDENT) || (k == K_TICK) || (k == K_STR);
  endfunction

  // Hex digit value; bit 4 set when not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (is_dec_char(c)) v = 5'(c - "0");
    else if ((c >= "a") && (c <= "f")) v = 5'(c - "a" + 8'd10);
    else if ((c >= "A") && (c <= "F")) v = 5'(c - "A" + 8'd10);
    return v;
  endfunction

endpackage

@@ rtl/ftl_in_if.sv @@
// Source byte channel: valid/ready with one byte per word.
// Depends on nothing.
interface ftl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

@@ rtl/ftl_out_if.sv @@
// Token result channel: valid/ready with one result per word.
// Depends on nothing.
interface ftl_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic signed [31:0] number_value;
  logic [7:0]         text_byte;
  logic [5:0]         text_length;
  logic [2:0]         error_code;
  logic               last_of_token;
  modport source (output valid, output token_kind, output number_value, output text_byte,
                  output text_length, output error_code, output last_of_token,
                  input ready);
  modport sink   (input valid, input token_kind, input number_value, input text_byte,
                  input text_length, input error_code, input last_of_token,
                  output ready);
endinterface

@@ rtl/ftl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ftl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem_r[rd_addr];
  end

endmodule

@@ rtl/ftl_front.sv @@
// Front end: takes source bytes, runs the scan state machine, stores word
// and string text, tracks number syntax, and pushes token descriptors.
// Depends on ftl_pkg.
module ftl_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  input  ftl_pkg::q_stat_t             q_stat,
  output logic                         push_valid,
  output ftl_pkg::tok_desc_t           push_desc,
  input  logic                         text_done,
  output logic                         wr_en,
  output logic [ftl_pkg::STORE_AW-1:0] wr_addr,
  output logic [7:0]                   wr_data
);

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_WORD  = 3'd1;
  localparam logic [2:0] M_TICK  = 3'd2;
  localparam logic [2:0] M_LINE  = 3'd3;
  localparam logic [2:0] M_PAREN = 3'd4;
  localparam logic [2:0] M_STR   = 3'd5;
  localparam logic [2:0] M_ESC   = 3'd6;

  localparam int CW = ftl_pkg::CELL_BITS;
  localparam int NW = ftl_pkg::CNT_W;

  // Held byte
  logic       full_r, full_nxt;
  logic [7:0] byte_r;

  // Scan state
  logic [2:0]                     mode_r, mode_nxt;
  logic [NW-1:0]                  cnt_r, cnt_nxt;
  logic [ftl_pkg::DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic                           first_p_r, first_p_nxt;
  logic                           lock_r, lock_nxt;

  // Number tracking: flags {neg, first_zero, first_digit, sec_x, sec_b}
  logic [4:0]    flags_r, flags_nxt;
  logic          dec_ok_r, dec_ok_nxt, hex_ok_r, hex_ok_nxt, bin_ok_r, bin_ok_nxt;
  logic [CW-1:0] dec_r, dec_nxt, hex_r, hex_nxt, bin_r, bin_nxt;

  // Tentative number update for a word byte
  logic [NW-1:0] pos;
  logic          neg_u;
  logic [NW:0]   rel;
  logic [4:0]    flags_u;
  logic          dec_ok_u, hex_ok_u, bin_ok_u;
  logic [CW-1:0] dec_u, hex_u, bin_u;
  logic [4:0]    hv;

  // Word finish
  logic          is_x, is_b, is_num;
  logic [NW:0]   ps2, ps3;
  logic [CW-1:0] mag, cellv;

  logic consume, go;

  // Number tracking for the byte at the current word position
  always_comb begin
    pos     = ((mode_r == M_WORD) || (mode_r == M_TICK)) ? cnt_r : '0;
    neg_u   = (pos == '0) ? (byte_r == "-") : flags_r[4];
    rel     = {1'b0, pos} - (NW+1)'(neg_u);
    flags_u = (pos == '0) ? 5'b0 : flags_r;
    flags_u[4] = neg_u;
    dec_ok_u = (pos == '0) ? 1'b1 : dec_ok_r;
    hex_ok_u = (pos == '0) ? 1'b1 : hex_ok_r;
    bin_ok_u = (pos == '0) ? 1'b1 : bin_ok_r;
    dec_u    = (pos == '0) ? '0 : dec_r;
    hex_u    = (pos == '0) ? '0 : hex_r;
    bin_u    = (pos == '0) ? '0 : bin_r;
    hv       = ftl_pkg::hex_val(byte_r);
    if (!rel[NW]) begin
      dec_ok_u = dec_ok_u & ftl_pkg::is_dec_char(byte_r);
      dec_u    = (dec_u << 3) + (dec_u << 1) + CW'(byte_r[3:0]);
      if (rel == '0) begin
        flags_u[3] = (byte_r == "0");
        flags_u[2] = ftl_pkg::is_dec_char(byte_r);
      end else if (rel == (NW+1)'(1)) begin
        flags_u[1] = (byte_r == "x");
        flags_u[0] = (byte_r == "b");
      end else begin
        hex_ok_u = hex_ok_u & ~hv[4];
        hex_u    = (hex_u << 4) | CW'(hv[3:0]);
        bin_ok_u = bin_ok_u & ((byte_r == "0") || (byte_r == "1"));
        bin_u    = (bin_u << 1) | CW'(byte_r[0]);
      end
    end
  end

  // Number decision for the stored word
  always_comb begin
    ps2    = (NW+1)'(2) + (NW+1)'(flags_r[4]);
    ps3    = (NW+1)'(3) + (NW+1)'(flags_r[4]);
    is_x   = flags_r[3] & flags_r[1] & ({1'b0, cnt_r} >= ps2);
    is_b   = flags_r[3] & flags_r[0] & ({1'b0, cnt_r} >= ps2);
    is_num = flags_r[2] & (is_x ? (({1'b0, cnt_r} >= ps3) & hex_ok_r) :
                           is_b ? (({1'b0, cnt_r} >= ps3) & bin_ok_r) : dec_ok_r);
    mag    = is_x ? hex_r : (is_b ? bin_r : dec_r);
    cellv  = flags_r[4] ? (CW'(0) - mag) : mag;
  end

  // Scan state machine
  always_comb begin
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    depth_nxt   = depth_r;
    first_p_nxt = first_p_r;
    flags_nxt   = flags_r;
    dec_ok_nxt  = dec_ok_r;
    hex_ok_nxt  = hex_ok_r;
    bin_ok_nxt  = bin_ok_r;
    dec_nxt     = dec_r;
    hex_nxt     = hex_r;
    bin_nxt     = bin_r;
    consume     = 1'b1;
    push_valid  = 1'b0;
    push_desc   = '0;
    wr_en       = 1'b0;
    wr_addr     = cnt_r[ftl_pkg::STORE_AW-1:0];
    wr_data     = byte_r;

    case (mode_r)
      M_WORD, M_TICK: begin
        if ((mode_r == M_WORD) && (cnt_r == NW'(1)) && first_p_r && (byte_r == "[")) begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_POPEN;
          mode_nxt       = M_IDLE;
          cnt_nxt        = '0;
        end else if (ftl_pkg::is_delim(byte_r)) begin
          // word ends; the delimiter stays held and starts the next token
          push_valid = 1'b1;
          consume    = 1'b0;
          if (mode_r == M_TICK) begin
            push_desc.kind = ftl_pkg::K_TICK;
            push_desc.len  = cnt_r;
          end else if (is_num) begin
            push_desc.kind  = ftl_pkg::K_NUM;
            push_desc.value = 32'($signed(cellv));
          end else begin
            push_desc.kind = ftl_pkg::K_IDENT;
            push_desc.len  = cnt_r;
          end
          mode_nxt = M_IDLE;
          cnt_nxt  = '0;
        end else if (cnt_r >= NW'(ftl_pkg::NAME_CAPACITY - 1)) begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_ERR;
          push_desc.err  = ftl_pkg::E_WORD_LONG;
          mode_nxt       = M_IDLE;
          cnt_nxt        = '0;
        end else begin
          wr_en      = 1'b1;
          cnt_nxt    = cnt_r + NW'(1);
          flags_nxt  = flags_u;
          dec_ok_nxt = dec_ok_u;
          hex_ok_nxt = hex_ok_u;
          bin_ok_nxt = bin_ok_u;
          dec_nxt    = dec_u;
          hex_nxt    = hex_u;
          bin_nxt    = bin_u;
        end
      end
      M_LINE: begin
        if (byte_r == 8'h0a) begin
          mode_nxt = M_IDLE;
        end else if (byte_r == 8'h00) begin
          mode_nxt       = M_IDLE;
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_EOF;
        end
      end
      M_PAREN: begin
        if (byte_r == 8'h00) begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_ERR;
          push_desc.err  = ftl_pkg::E_OPEN_COMMENT;
          mode_nxt       = M_IDLE;
          cnt_nxt        = '0;
        end else if (byte_r == "(") begin
          if (depth_r != '1) depth_nxt = depth_r + ftl_pkg::DEPTH_BITS'(1);
        end else if (byte_r == ")") begin
          if (depth_r != '0) depth_nxt = depth_r - ftl_pkg::DEPTH_BITS'(1);
          if ((depth_r == '0) || (depth_r == ftl_pkg::DEPTH_BITS'(1))) mode_nxt = M_IDLE;
        end
      end
      M_STR: begin
        if (byte_r == 8'h00) begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_ERR;
          push_desc.err  = ftl_pkg::E_OPEN_STRING;
          mode_nxt       = M_IDLE;
          cnt_nxt        = '0;
        end else if (byte_r == 8'h22) begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_STR;
          push_desc.len  = cnt_r;
          mode_nxt       = M_IDLE;
          cnt_nxt        = '0;
        end else if (cnt_r >= NW'(ftl_pkg::STRING_CAPACITY)) begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_ERR;
          push_desc.err  = ftl_pkg::E_STRING_LONG;
          mode_nxt       = M_IDLE;
          cnt_nxt        = '0;
        end else if (byte_r == 8'h5c) begin
          mode_nxt = M_ESC;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      M_ESC: begin
        if (byte_r == 8'h00) begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_ERR;
          push_desc.err  = ftl_pkg::E_OPEN_STRING;
          mode_nxt       = M_IDLE;
          cnt_nxt        = '0;
        end else if ((byte_r == 8'h5c) || (byte_r == 8'h22) || (byte_r == "n") ||
                     (byte_r == "r") || (byte_r == "t")) begin
          wr_en    = 1'b1;
          wr_data  = (byte_r == "n") ? 8'h0a : (byte_r == "r") ? 8'h0d :
                     (byte_r == "t") ? 8'h09 : byte_r;
          cnt_nxt  = cnt_r + NW'(1);
          mode_nxt = M_STR;
        end else begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_ERR;
          push_desc.err  = ftl_pkg::E_BAD_ESCAPE;
          mode_nxt       = M_IDLE;
          cnt_nxt        = '0;
        end
      end
      default: begin
        // between tokens: start of a new token
        mode_nxt = M_IDLE;
        cnt_nxt  = '0;
        if (byte_r == 8'h00) begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_EOF;
        end else if (ftl_pkg::is_space(byte_r)) begin
          mode_nxt = M_IDLE;
        end else if (byte_r == 8'h5c) begin
          mode_nxt = M_LINE;
        end else if (byte_r == "(") begin
          mode_nxt  = M_PAREN;
          depth_nxt = ftl_pkg::DEPTH_BITS'(1);
        end else if (byte_r == ")") begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_ERR;
          push_desc.err  = ftl_pkg::E_STRAY_PAREN;
        end else if (byte_r == 8'h22) begin
          mode_nxt = M_STR;
        end else if (byte_r == "[") begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_OPEN;
        end else if ((byte_r == "]") || (byte_r == ";")) begin
          push_valid     = 1'b1;
          push_desc.kind = ftl_pkg::K_CLOSE;
        end else if (byte_r == 8'h27) begin
          mode_nxt = M_TICK;
        end else begin
          mode_nxt    = M_WORD;
          wr_en       = 1'b1;
          wr_addr     = '0;
          cnt_nxt     = NW'(1);
          first_p_nxt = (byte_r == "p");
          flags_nxt   = flags_u;
          dec_ok_nxt  = dec_ok_u;
          hex_ok_nxt  = hex_ok_u;
          bin_ok_nxt  = bin_ok_u;
          dec_nxt     = dec_u;
          hex_nxt     = hex_u;
          bin_nxt     = bin_u;
        end
      end
    endcase
  end

  // Step only when a byte is held, the queue has room and the byte would not write the text store while it is read out
  assign go       = full_r & ~q_stat.full & ~(wr_en & lock_r);
  assign in_ready = ~full_r | (go & consume);
  assign full_nxt = (in_valid & in_ready) | (full_r & ~(go & consume));
  assign lock_nxt = (lock_r & ~text_done) |
                    (go & push_valid & ftl_pkg::is_text_kind(push_desc.kind) &
                     (push_desc.len != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r    <= 1'b0;
      mode_r    <= M_IDLE;
      cnt_r     <= '0;
      depth_r   <= '0;
      lock_r    <= 1'b0;
      first_p_r <= 1'b0;
      flags_r   <= '0;
      dec_ok_r  <= 1'b0;
      hex_ok_r  <= 1'b0;
      bin_ok_r  <= 1'b0;
      dec_r     <= '0;
      hex_r     <= '0;
      bin_r     <= '0;
    end else begin
      full_r <= full_nxt;
      lock_r <= lock_nxt;
      if (go) begin
        mode_r    <= mode_nxt;
        cnt_r     <= cnt_nxt;
        depth_r   <= depth_nxt;
        first_p_r <= first_p_nxt;
        flags_r   <= flags_nxt;
        dec_ok_r  <= dec_ok_nxt;
        hex_ok_r  <= hex_ok_nxt;
        bin_ok_r  <= bin_ok_nxt;
        dec_r     <= dec_nxt;
        hex_r     <= hex_nxt;
        bin_r     <= bin_nxt;
      end
    end
  end

  // Byte holding register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_r <= in_byte;
  end

endmodule

@@ rtl/ftl_queue.sv @@
// Two-entry descriptor queue between the front and back ends.
// Depends on ftl_pkg.
module ftl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ftl_pkg::tok_desc_t push_desc,
  input  logic               pop,
  output ftl_pkg::tok_desc_t head,
  output ftl_pkg::q_stat_t   stat
);

  ftl_pkg::tok_desc_t ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head       = ent_r[rp_r];
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign wp_nxt     = wp_r ^ do_push;
  assign rp_nxt     = rp_r ^ do_pop;
  assign cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entries
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_desc;
  end

endmodule

@@ rtl/ftl_back.sv @@
// Back end: pops token descriptors and emits result words, streaming
// name and string bytes out of the text store. Depends on ftl_pkg.
module ftl_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ftl_pkg::q_stat_t             q_stat,
  input  ftl_pkg::tok_desc_t           head,
  output logic                         pop,
  output logic                         rd_en,
  output logic [ftl_pkg::STORE_AW-1:0] rd_addr,
  input  logic [7:0]                   rd_data,
  output logic                         text_done,
  ftl_out_if.source                    out_ch
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RD   = 2'd1;
  localparam logic [1:0] B_OUT  = 2'd2;

  localparam int NW = ftl_pkg::CNT_W;

  logic [1:0]         st_r, st_nxt;
  ftl_pkg::tok_desc_t cur_r;
  logic [NW-1:0]      idx_r, idx_nxt;
  logic               text_r;
  logic               valid_r;
  logic [7:0]         byte_r;
  logic               last_r;
  logic               start_text, load_single, load_text;

  assign start_text  = ftl_pkg::is_text_kind(head.kind) & (head.len != '0);
  assign pop         = (st_r == B_IDLE) & ~q_stat.empty;
  assign load_single = pop & ~start_text;
  assign load_text   = (st_r == B_RD);
  assign text_done   = (st_r == B_OUT) & out_ch.ready & last_r & text_r;

  // Sequencer
  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    rd_en   = 1'b0;
    rd_addr = idx_r[ftl_pkg::STORE_AW-1:0];
    case (st_r)
      B_IDLE: begin
        if (pop) begin
          idx_nxt = '0;
          if (start_text) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            st_nxt  = B_RD;
          end else begin
            st_nxt = B_OUT;
          end
        end
      end
      B_RD: st_nxt = B_OUT;
      B_OUT: begin
        if (out_ch.ready) begin
          if (last_r) begin
            st_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r + NW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_nxt[ftl_pkg::STORE_AW-1:0];
            st_nxt  = B_RD;
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      idx_r   <= idx_nxt;
      valid_r <= load_single | load_text | (valid_r & ~out_ch.ready);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= head;
      text_r <= start_text;
    end
    if (load_single) begin
      byte_r <= '0;
      last_r <= 1'b1;
    end else if (load_text) begin
      byte_r <= rd_data;
      last_r <= ((idx_r + NW'(1)) == cur_r.len);
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.token_kind    = cur_r.kind;
  assign out_ch.number_value  = cur_r.value;
  assign out_ch.text_byte     = byte_r;
  assign out_ch.text_length   = 6'(cur_r.len);
  assign out_ch.error_code    = cur_r.err;
  assign out_ch.last_of_token = last_r;

endmodule

@@ rtl/forth_token_lexer.sv @@
// Top level of the Forth token lexer: front end, descriptor queue, back end
// and text store. Depends on ftl_pkg, ftl_in_if, ftl_out_if, ftl_front, ftl_queue, ftl_ram and ftl_back.
//
// Takes one source byte per word and returns token result words. A byte is
// held while it is scanned, and the next byte is taken in the same cycle as
// the held byte is consumed. The back end pops a descriptor when idle and
// offers the result word in its output state; the front end stalls while the
// two-entry queue is full. A byte that ends a word is scanned again as the
// start of the next token. Each name or string byte goes out in its own
// word, read from the registered text store in the back end's read state
// and offered in its output state. The front end keeps scanning while
// results drain through the queue, but stalls on a byte that would write
// the text store while stored text is still being read out.
module forth_token_lexer (
  input  logic      clk,
  input  logic      rst_n,
  ftl_in_if.sink    in_ch,
  ftl_out_if.source out_ch
);

  ftl_pkg::q_stat_t             q_stat;
  ftl_pkg::tok_desc_t           push_desc, head;
  logic                         push_valid, pop, text_done;
  logic                         wr_en, rd_en;
  logic [ftl_pkg::STORE_AW-1:0] wr_addr, rd_addr;
  logic [7:0]                   wr_data, rd_data;

  ftl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.byte_value),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .text_done  (text_done),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  ftl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid & u_front.go),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  ftl_ram #(.WIDTH(8), .DEPTH(ftl_pkg::STORE_DEPTH)) u_text (
    .clk     (clk),
    .wr_en   (wr_en & u_front.go),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ftl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .text_done (text_done),
    .out_ch    (out_ch)
  );

endmodule

@@ rtl/ftl_checker.sv @@
// Port-level checks for the Forth token lexer, bound to the top level.
// Depends on ftl_pkg and forth_token_lexer.
module ftl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [3:0]        token_kind,
  input logic signed [31:0] number_value,
  input logic [5:0]        text_length,
  input logic [2:0]        error_code,
  input logic              last_of_token
);

  // Stalled result word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Nothing offered right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only number tokens carry a value
  a_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind != ftl_pkg::K_NUM) |-> (number_value == 0))
    else $error("value on a non-number word");

  // Errors are single words without text
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind == ftl_pkg::K_ERR) |-> last_of_token && (text_length == 0))
    else $error("malformed error word");

  // Error code only on errors
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind != ftl_pkg::K_ERR) |-> (error_code == 3'd0))
    else $error("error code on a non-error word");

endmodule

bind forth_token_lexer ftl_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .token_kind    (out_ch.token_kind),
  .number_value  (out_ch.number_value),
  .text_length   (out_ch.text_length),
  .error_code    (out_ch.error_code),
  .last_of_token (out_ch.last_of_token)
);

@@ verif/tb.sv @@
// Self-checking testbench for forth_token_lexer: source bytes go in, and the
// token results are checked against a predictor kept in the scoreboard.
// Depends on ftl_pkg, ftl_in_if, ftl_out_if and the lexer RTL.
module tb;

  // One token result word
  typedef struct {
    logic [3:0]  kind;
    logic [31:0] num;
    logic [7:0]  tbyte;
    logic [5:0]  len;
    logic [2:0]  err;
    logic        last;
  } tok_res_t;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_TICK, SCAN_LINE, SCAN_PAREN, SCAN_STR, SCAN_ESC
  } scan_t;

  // Lexer predictor plus the queue of tokens still due
  class token_board;
    scan_t       mode;
    logic [7:0]  text[64];
    int unsigned text_n;
    logic [15:0] depth;
    tok_res_t    due[$];
    int          fails;
    int          words_in;
    int          words_out;

    function new();
      mode = SCAN_IDLE;
      text_n = 0;
      depth = '0;
      fails = 0;
      words_in = 0;
      words_out = 0;
      foreach (text[i]) text[i] = 8'h00;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      fails++;
    endtask

    function void emit(logic [3:0] k, logic [31:0] v, logic [7:0] b, logic [5:0] n,
                       logic [2:0] e, logic l);
      tok_res_t r;
      r.kind = k; r.num = v; r.tbyte = b; r.len = n; r.err = e; r.last = l;
      due.push_back(r);
    endfunction

    function void lex_error(logic [2:0] code);
      mode = SCAN_IDLE;
      text_n = 0;
      depth = '0;
      emit(ftl_pkg::K_ERR, '0, '0, '0, code, 1'b1);
    endfunction

    function void emit_text(logic [3:0] k);
      if (text_n == 0) emit(k, '0, '0, '0, '0, 1'b1);
      for (int i = 0; i < text_n; i++)
        emit(k, '0, text[i], 6'(text_n), '0, (i + 1) == text_n);
    endfunction

    static function logic [4:0] hexdig(logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
      return 5'h10;
    endfunction

    // Stored word as a number; cell is 32 bits so wrap is native
    function logic as_number(output logic [31:0] v);
      int unsigned p;
      logic neg;
      logic [4:0] d;
      p = 0;
      v = '0;
      neg = 1'b0;
      if (text_n > 0 && text[0] == "-") begin
        neg = 1'b1;
        p = 1;
      end
      if (p >= text_n || !(text[p] >= "0" && text[p] <= "9")) return 1'b0;
      if (text[p] == "0" && p + 1 < text_n && text[p+1] == "x") begin
        p += 2;
        if (p >= text_n) return 1'b0;
        for (; p < text_n; p++) begin
          d = hexdig(text[p]);
          if (d[4]) return 1'b0;
          v = {v[27:0], d[3:0]};
        end
      end else if (text[p] == "0" && p + 1 < text_n && text[p+1] == "b") begin
        p += 2;
        if (p >= text_n) return 1'b0;
        for (; p < text_n; p++) begin
          if (text[p] != "0" && text[p] != "1") return 1'b0;
          v = {v[30:0], text[p][0]};
        end
      end else begin
        for (; p < text_n; p++) begin
          if (!(text[p] >= "0" && text[p] <= "9")) return 1'b0;
          v = v * 10 + 32'(text[p] - "0");
        end
      end
      if (neg) v = -v;
      return 1'b1;
    endfunction

    function void end_word();
      logic [31:0] v;
      if (mode == SCAN_TICK) emit_text(ftl_pkg::K_TICK);
      else if (as_number(v)) emit(ftl_pkg::K_NUM, v, '0, '0, '0, 1'b1);
      else emit_text(ftl_pkg::K_IDENT);
      mode = SCAN_IDLE;
      text_n = 0;
    endfunction

    function void begin_token(logic [7:0] b);
      mode = SCAN_IDLE;
      text_n = 0;
      if (b == 8'h00) emit(ftl_pkg::K_EOF, '0, '0, '0, '0, 1'b1);
      else if (ftl_pkg::is_space(b)) ;
      else if (b == "\\") mode = SCAN_LINE;
      else if (b == "(") begin
        mode = SCAN_PAREN;
        depth = 16'd1;
      end
      else if (b == ")") lex_error(ftl_pkg::E_STRAY_PAREN);
      else if (b == 8'h22) mode = SCAN_STR;
      else if (b == "[") emit(ftl_pkg::K_OPEN, '0, '0, '0, '0, 1'b1);
      else if (b == "]" || b == ";") emit(ftl_pkg::K_CLOSE, '0, '0, '0, '0, 1'b1);
      else if (b == 8'h27) mode = SCAN_TICK;
      else begin
        mode = SCAN_WORD;
        text[0] = b;
        text_n = 1;
      end
    endfunction

    // Accepted source byte
    function void note_byte(logic [7:0] b);
      words_in++;
      case (mode)
        SCAN_WORD, SCAN_TICK: begin
          if (mode == SCAN_WORD && text_n == 1 && text[0] == "p" && b == "[") begin
            mode = SCAN_IDLE;
            text_n = 0;
            emit(ftl_pkg::K_POPEN, '0, '0, '0, '0, 1'b1);
          end else if (ftl_pkg::is_delim(b)) begin
            end_word();
            begin_token(b);
          end else if (text_n >= ftl_pkg::NAME_CAPACITY - 1) lex_error(ftl_pkg::E_WORD_LONG);
          else text[text_n++] = b;
        end
        SCAN_LINE: begin
          if (b == 8'h0a) mode = SCAN_IDLE;
          else if (b == 8'h00) begin
            mode = SCAN_IDLE;
            emit(ftl_pkg::K_EOF, '0, '0, '0, '0, 1'b1);
          end
        end
        SCAN_PAREN: begin
          if (b == 8'h00) lex_error(ftl_pkg::E_OPEN_COMMENT);
          else if (b == "(") begin
            if (depth != 16'hFFFF) depth++;
          end else if (b == ")") begin
            if (depth != 0) depth--;
            if (depth == 0) mode = SCAN_IDLE;
          end
        end
        SCAN_STR: begin
          if (b == 8'h00) lex_error(ftl_pkg::E_OPEN_STRING);
          else if (b == 8'h22) begin
            emit_text(ftl_pkg::K_STR);
            mode = SCAN_IDLE;
            text_n = 0;
          end
          else if (text_n >= ftl_pkg::STRING_CAPACITY) lex_error(ftl_pkg::E_STRING_LONG);
          else if (b == "\\") mode = SCAN_ESC;
          else text[text_n++] = b;
        end
        SCAN_ESC: begin
          if (b == 8'h00) lex_error(ftl_pkg::E_OPEN_STRING);
          else if (b == "\\" || b == 8'h22 || b == "n" || b == "r" || b == "t") begin
            text[text_n++] = (b == "n") ? 8'h0a : (b == "r") ? 8'h0d :
                             (b == "t") ? 8'h09 : b;
            mode = SCAN_STR;
          end
          else lex_error(ftl_pkg::E_BAD_ESCAPE);
        end
        default: begin_token(b);
      endcase
    endfunction

    // Accepted result word against the oldest token due
    task check_word(tok_res_t got);
      tok_res_t w;
      words_out++;
      if (due.size() == 0) begin
        report($sformatf("unexpected result kind=%0d", got.kind));
        return;
      end
      w = due.pop_front();
      if (got.kind !== w.kind)
        report($sformatf("kind got %0d want %0d", got.kind, w.kind));
      if (got.num !== w.num)
        report($sformatf("number_value got %0h want %0h", got.num, w.num));
      if (got.tbyte !== w.tbyte)
        report($sformatf("text_byte got %0h want %0h", got.tbyte, w.tbyte));
      if (got.len !== w.len)
        report($sformatf("text_length got %0d want %0d", got.len, w.len));
      if (got.err !== w.err)
        report($sformatf("error_code got %0d want %0d", got.err, w.err));
      if (got.last !== w.last)
        report($sformatf("last_of_token got %0b want %0b", got.last, w.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  ftl_in_if  in_ch();
  ftl_out_if out_ch();

  forth_token_lexer u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  token_board board = new();
  bit     no_gaps = 1'b0;
  bit     hold_long = 1'b0;
  logic [7:0] src_q[$];
  int     idle_cycles = 0;

  // Push the characters of a string onto the source queue
  task add_str(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s.getc(i));
  endtask

  task add_rand(string set, int n);
    for (int i = 0; i < n; i++) src_q.push_back(set.getc($urandom_range(0, set.len() - 1)));
  endtask

  // Offer one byte and wait for the handshake
  task send_byte(logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_value <= b;
    do @(posedge clk); while (!in_ch.ready);
    board.note_byte(b);
  endtask

  task drain_src();
    while (src_q.size() > 0) send_byte(src_q.pop_front());
  endtask

  // Result side: random stalls, and one long hold when asked
  initial begin
    tok_res_t r;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = hold_long ? 400 : (no_gaps ? 0 : $urandom_range(0, 13));
      if (hold_long) hold_long = 1'b0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      r.kind = out_ch.token_kind; r.num = out_ch.number_value;
      r.tbyte = out_ch.text_byte; r.len = out_ch.text_length;
      r.err = out_ch.error_code; r.last = out_ch.last_of_token;
      board.check_word(r);
    end
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == 20000) begin
        $display("watchdog: no progress, %0d tokens still due", board.due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int rnd_bytes;
    bit paused_done;
    in_ch.valid = 1'b0;
    in_ch.byte_value = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every token kind, number forms and wrap, each error
    add_str("[ ] ; p[ 'abc '; \"\" \"a\\n\\r\\t\\\\\\\"b\" 42 -17 0x7fFFffff 0b101 ");
    add_str("-0x80000000 99999999999 0xg 0b12 0x - -0b foo\n\\ line\n");
    src_q.push_back(8'h00);
    add_str("( a ( b ) c ) ) abcdefghijklmnopqrstuvwxyz012345 ");
    add_str("\"abcdefghijklmnopqrstuvwxyz0123456\" \"a\\q \"abc");
    src_q.push_back(8'h00);
    add_str("( x");
    src_q.push_back(8'h00);
    add_str("\\ x");
    src_q.push_back(8'h00);
    add_str("\"\\");
    src_q.push_back(8'h00);
    add_str("'x]");
    drain_src();

    // Random token sequences with some noise; long result hold at the start
    rnd_bytes = 0;
    paused_done = 1'b0;
    hold_long = 1'b1;
    while (rnd_bytes < 60) begin
      pick = $urandom_range(0, 11);
      if (pick == 0 || pick == 1) begin
        if ($urandom_range(0, 1)) add_str("-");
        if (pick == 1) begin
          add_str("0x");
          add_rand("0123456789abcdefABCDEF", $urandom_range(1, 9));
        end else add_rand("0123456789", $urandom_range(1, 12));
      end
      else if (pick == 2) begin
        add_str("0b");
        add_rand("01", $urandom_range(1, 35));
      end
      else if (pick == 3) add_rand("abcxyzp-0x9+*", $urandom_range(1, 8));
      else if (pick == 4) add_rand("abqz", $urandom_range(29, 33));
      else if (pick == 5 || pick == 10) begin
        add_str("\"");
        for (int i = $urandom_range(0, pick == 10 ? 34 : 8); i > 0; i--) begin
          if ($urandom_range(0, 4) == 0) begin
            add_str("\\");
            add_rand("\\\"nrtnrtq", 1);
          end
          else add_rand("hello world;(", 1);
        end
        add_str("\"");
      end
      else if (pick == 6) begin
        add_str("'");
        add_rand("tickname", $urandom_range(0, 6));
      end
      else if (pick == 7) add_rand("[];p", $urandom_range(1, 3));
      else if (pick == 8) add_str($urandom_range(0, 1) ? "\\ note ; x\n" : "( a (b) c )");
      else if (pick == 9) begin
        for (int i = $urandom_range(1, 3); i > 0; i--) src_q.push_back(8'($urandom));
      end
      else src_q.push_back(8'h00);
      add_rand(" \t\r\n;[]'\"", 1);
      rnd_bytes += src_q.size();
      if (pick == 7 && $urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
      // Sender pauses once until every expected result is out
      if (!paused_done && rnd_bytes > 30) begin
        paused_done = 1'b1;
        in_ch.valid <= 1'b0;
        wait (board.due.size() == 0);
        @(posedge clk);
      end
      drain_src();
    end
    in_ch.valid <= 1'b0;

    wait (board.due.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d source bytes and %0d result words over all token and error kinds,",
             board.words_in, board.words_out);
    $display("with random idles on both sides, a long result hold and a drained pause.");
    if (board.fails == 0 && board.due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
